// ----- rtl/opr_pkg.sv -----
// Shared types, widths and state codes of the optimal page replacement core.
package opr_pkg;

  localparam int PAGE_W          = 16;
  localparam int REF_IDX_W       = 6;
  localparam int VICTIM_W        = 3;
  localparam int COUNT_W         = 7;
  localparam int CFG_W           = 4;
  localparam int FRAME_COUNT_RST = 4;

  typedef struct packed {
    logic [PAGE_W-1:0] page;
    logic              last_ref;
  } in_item_t;

  typedef struct packed {
    logic [REF_IDX_W-1:0] ref_index;
    logic [PAGE_W-1:0]    page_res;
    logic                 hit;
    logic [VICTIM_W-1:0]  victim_frame;
    logic                 evicted_valid;
    logic [PAGE_W-1:0]    evicted_page;
    logic [COUNT_W-1:0]   hit_count;
    logic [COUNT_W-1:0]   miss_count;
    logic                 last_result;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_FETCH,
    ST_LATCH,
    ST_DECIDE,
    ST_SCAN
  } opr_state_t;

  typedef struct packed {
    logic load;
    logic start_replay;
    logic fetch;
    logic latch;
    logic scan_init;
    logic scan_step;
    logic commit;
  } opr_cmd_t;

  typedef struct packed {
    logic hit;
    logic fill;
    logic scan_done;
    logic last;
  } opr_status_t;

endpackage

// ----- rtl/opr_ctrl.sv -----
// Sequencer for loading the reference string and replaying it one reference at a time.
module opr_ctrl import opr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        last_ref,
  input  opr_status_t status,
  output opr_cmd_t    cmd,
  output logic        busy,
  output logic        out_valid
);

  opr_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    case (state_r)
      ST_LOAD: begin
        if (start) begin
          cmd.load = 1'b1;
          if (last_ref) begin
            cmd.start_replay = 1'b1;
            state_nxt        = ST_FETCH;
          end
        end
      end
      ST_FETCH: begin
        cmd.fetch = 1'b1;
        state_nxt = ST_LATCH;
      end
      ST_LATCH: begin
        cmd.latch = 1'b1;
        state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (status.hit || status.fill) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = status.last ? ST_LOAD : ST_FETCH;
        end else begin
          cmd.scan_init = 1'b1;
          state_nxt     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status.scan_done) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = status.last ? ST_LOAD : ST_FETCH;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  assign busy      = (state_r != ST_LOAD);
  assign out_valid = out_valid_r;

endmodule

// ----- rtl/opr_dpath.sv -----
// Reference memory, frame table, forward-use scan and result register.
module opr_dpath import opr_pkg::*; #(
  parameter int REF_MAX    = 64,
  parameter int FRAMES_MAX = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  in_item_t         in_data,
  input  logic             cfg_valid,
  input  logic [CFG_W-1:0] cfg_data,
  input  opr_cmd_t         cmd,
  output opr_status_t      status,
  output out_item_t        out_data
);

  localparam int AW  = $clog2(REF_MAX);
  localparam int IW  = $clog2(REF_MAX + 1);
  localparam int FW  = (FRAMES_MAX > 1) ? $clog2(FRAMES_MAX) : 1;
  localparam int NFW = $clog2(FRAMES_MAX + 1);

  logic [PAGE_W-1:0]     ref_mem [REF_MAX];
  logic [PAGE_W-1:0]     rd_data_r;
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic                  store_en;

  logic [IW-1:0]         cnt_r, cnt_nxt;
  logic [IW-1:0]         idx_r, idx_nxt;
  logic [IW-1:0]         scan_k_r, scan_k_nxt;
  logic [CFG_W-1:0]      fc_r, fc_nxt;
  logic [NFW-1:0]        nf_r, nf_nxt;
  logic [PAGE_W-1:0]     cur_page_r, cur_page_nxt;
  logic [PAGE_W-1:0]     frame_page_r [FRAMES_MAX];
  logic [FRAMES_MAX-1:0] fvalid_r, fvalid_nxt;
  logic [FRAMES_MAX-1:0] found_r, found_nxt;
  logic [FW-1:0]         last_found_r, last_found_nxt;
  logic                  rd_pend_r, rd_pend_nxt;
  logic [COUNT_W-1:0]    hits_r, hits_nxt;
  logic [COUNT_W-1:0]    misses_r, misses_nxt;
  out_item_t             res_r, res_nxt;

  logic                  hit_c;
  logic                  fill_c;
  logic                  last_c;
  logic                  all_found_c;
  logic                  never_any_c;
  logic [FW-1:0]         never_idx_c;
  logic [FW-1:0]         victim_c;
  logic                  ev_valid_c;

  // Frame status: hit test and lowest frame that is empty or has no further use.
  always_comb begin
    hit_c       = 1'b0;
    all_found_c = 1'b1;
    never_any_c = 1'b0;
    never_idx_c = '0;
    for (int j = FRAMES_MAX - 1; j >= 0; j--) begin
      if (j < int'(nf_r)) begin
        if (fvalid_r[j] && frame_page_r[j] == cur_page_r) hit_c = 1'b1;
        if (!fvalid_r[j] || !found_r[j]) begin
          never_any_c = 1'b1;
          never_idx_c = FW'(j);
        end
        if (fvalid_r[j] && !found_r[j]) all_found_c = 1'b0;
      end
    end
  end

  assign fill_c = (32'(idx_r) < 32'(nf_r));
  assign last_c = ((idx_r + IW'(1)) == cnt_r);
  // The frame matched last in the scan has the farthest next use.
  assign victim_c   = fill_c ? FW'(idx_r) : (never_any_c ? never_idx_c : last_found_r);
  assign ev_valid_c = !hit_c && fvalid_r[victim_c];

  assign status.hit       = hit_c;
  assign status.fill      = fill_c;
  assign status.last      = last_c;
  assign status.scan_done = all_found_c || ((scan_k_r >= cnt_r) && !rd_pend_r);

  // Reference memory: one write port, one registered read port.
  assign store_en = cmd.load && (cnt_r < IW'(REF_MAX));

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = idx_r[AW-1:0];
    if (cmd.fetch) begin
      rd_en = 1'b1;
    end else if (cmd.scan_step && (scan_k_r < cnt_r)) begin
      rd_en   = 1'b1;
      rd_addr = scan_k_r[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (store_en) ref_mem[cnt_r[AW-1:0]] <= in_data.page;
    if (rd_en) rd_data_r <= ref_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && !hit_c) frame_page_r[victim_c] <= cur_page_r;
  end

  always_comb begin
    cnt_nxt        = cnt_r;
    idx_nxt        = idx_r;
    scan_k_nxt     = scan_k_r;
    fc_nxt         = fc_r;
    nf_nxt         = nf_r;
    cur_page_nxt   = cur_page_r;
    fvalid_nxt     = fvalid_r;
    found_nxt      = found_r;
    last_found_nxt = last_found_r;
    rd_pend_nxt    = rd_pend_r;
    hits_nxt       = hits_r;
    misses_nxt     = misses_r;
    res_nxt        = res_r;

    if (cfg_valid) fc_nxt = cfg_data;

    if (store_en) cnt_nxt = cnt_r + IW'(1);

    if (cmd.start_replay) begin
      if (fc_r == '0) begin
        nf_nxt = NFW'(1);
      end else if (32'(fc_r) > 32'(FRAMES_MAX)) begin
        nf_nxt = NFW'(FRAMES_MAX);
      end else begin
        nf_nxt = NFW'(fc_r);
      end
      fvalid_nxt = '0;
      hits_nxt   = '0;
      misses_nxt = '0;
      idx_nxt    = '0;
    end

    if (cmd.latch) cur_page_nxt = rd_data_r;

    if (cmd.scan_init) begin
      scan_k_nxt     = idx_r + IW'(1);
      found_nxt      = '0;
      last_found_nxt = '0;
      rd_pend_nxt    = 1'b0;
    end

    if (cmd.scan_step) begin
      rd_pend_nxt = (scan_k_r < cnt_r);
      if (scan_k_r < cnt_r) scan_k_nxt = scan_k_r + IW'(1);
      // Mark each frame at the first later word that holds its page.
      if (rd_pend_r) begin
        for (int j = 0; j < FRAMES_MAX; j++) begin
          if (j < int'(nf_r) && fvalid_r[j] && !found_r[j] &&
              frame_page_r[j] == rd_data_r) begin
            found_nxt[j]   = 1'b1;
            last_found_nxt = FW'(j);
          end
        end
      end
    end

    if (cmd.commit) begin
      res_nxt.ref_index     = REF_IDX_W'(idx_r);
      res_nxt.page_res      = cur_page_r;
      res_nxt.hit           = hit_c;
      res_nxt.victim_frame  = hit_c ? '0 : VICTIM_W'(victim_c);
      res_nxt.evicted_valid = ev_valid_c;
      res_nxt.evicted_page  = ev_valid_c ? frame_page_r[victim_c] : '0;
      res_nxt.last_result   = last_c;
      if (hit_c) begin
        hits_nxt = hits_r + COUNT_W'(1);
      end else begin
        misses_nxt           = misses_r + COUNT_W'(1);
        fvalid_nxt[victim_c] = 1'b1;
      end
      res_nxt.hit_count  = hits_nxt;
      res_nxt.miss_count = misses_nxt;
      idx_nxt            = idx_r + IW'(1);
      rd_pend_nxt        = 1'b0;
      if (last_c) cnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      fc_r      <= CFG_W'(FRAME_COUNT_RST);
      fvalid_r  <= '0;
      found_r   <= '0;
      rd_pend_r <= 1'b0;
      hits_r    <= '0;
      misses_r  <= '0;
    end else begin
      cnt_r     <= cnt_nxt;
      fc_r      <= fc_nxt;
      fvalid_r  <= fvalid_nxt;
      found_r   <= found_nxt;
      rd_pend_r <= rd_pend_nxt;
      hits_r    <= hits_nxt;
      misses_r  <= misses_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    scan_k_r     <= scan_k_nxt;
    nf_r         <= nf_nxt;
    cur_page_r   <= cur_page_nxt;
    last_found_r <= last_found_nxt;
    res_r        <= res_nxt;
  end

  assign out_data = res_r;

endmodule

// ----- rtl/optimal_page_replacement_core.sv -----
// Top level of the optimal (farthest next use) page replacement core.
//
//   channel  | handshake               | word
//   ---------+-------------------------+------------------------------
//   input    | start / busy            | in_data  (page, last_ref)
//   result   | out_valid strobe        | out_data (one per reference)
//   config   | cfg_valid / cfg_ready   | cfg_data (frame_count)
//
// Loading takes one word per cycle; busy stays low until the word marked last_ref.
// Replay: each reference passes through fetch, latch and decide; on an eviction a
// forward scan follows, one future reference read per cycle from the single read
// port of the reference memory. Results go out one per reference.
// Reset clears counts, frame valid bits and state; no clearing pass.
// Results cannot be held off by the receiver.
module optimal_page_replacement_core import opr_pkg::*; #(
  parameter int REF_MAX    = 64,
  parameter int FRAMES_MAX = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  in_item_t         in_data,
  output logic             out_valid,
  output out_item_t        out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data
);

  opr_cmd_t    cmd;
  opr_status_t status;

  assign cfg_ready = 1'b1;

  opr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .last_ref  (in_data.last_ref),
    .status    (status),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  opr_dpath #(
    .REF_MAX    (REF_MAX),
    .FRAMES_MAX (FRAMES_MAX)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .out_data  (out_data)
  );

endmodule

// ----- bench/tb.sv -----
// Testbench for optimal_page_replacement_core: directed table of reference strings, then random strings.
module tb;
  import opr_pkg::*;

  localparam int REF_MAX     = 64;
  localparam int FRAMES_MAX  = 8;
  localparam int RAND_WORDS  = 270;
  localparam int SETTLE      = 8;
  localparam int STALL_LIMIT = 1000;
  localparam int DIR_N       = 22;

  typedef struct packed {
    logic             cfg_wr;
    logic [CFG_W-1:0] cfg_val;
    in_item_t         word;
    logic             typed;
    out_item_t        want;
  } dir_row_t;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             start     = 1'b0;
  logic             busy;
  in_item_t         in_data   = '0;
  logic             out_valid;
  out_item_t        out_data;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_data  = '0;

  logic [PAGE_W-1:0] loaded_pages[$];
  out_item_t         replay_due[$];
  logic [CFG_W-1:0]  frames_reg   = CFG_W'(FRAME_COUNT_RST);
  int unsigned       mismatches   = 0;
  int unsigned       stall_cycles = 0;
  int unsigned       idle_pct     = 0;
  int unsigned       words_sent   = 0;

  dir_row_t dir_table [DIR_N] = '{
    // cfg_wr, frames, {page, last_ref}, typed, {idx, page, hit, victim, ev_v, ev_pg, hits, misses, last}
    '{1'b0, 4'd0,  '{16'hFFFF, 1'b1}, 1'b1,
      '{6'd0, 16'hFFFF, 1'b0, 3'd0, 1'b0, 16'h0, 7'd0, 7'd1, 1'b1}},
    '{1'b0, 4'd0,  '{16'h0000, 1'b1}, 1'b1,
      '{6'd0, 16'h0000, 1'b0, 3'd0, 1'b0, 16'h0, 7'd0, 7'd1, 1'b1}},
    // two frames: evict the farthest next use, final miss goes to frame 0
    '{1'b1, 4'd2,  '{16'd1, 1'b0}, 1'b0, '0},
    '{1'b0, 4'd0,  '{16'd2, 1'b0}, 1'b0, '0},
    '{1'b0, 4'd0,  '{16'd3, 1'b0}, 1'b0, '0},
    '{1'b0, 4'd0,  '{16'd1, 1'b0}, 1'b0, '0},
    '{1'b0, 4'd0,  '{16'd2, 1'b0}, 1'b0, '0},
    '{1'b0, 4'd0,  '{16'd4, 1'b1}, 1'b0, '0},
    // hit during fill leaves frame 1 empty; pick it on the first eviction
    '{1'b1, 4'd4,  '{16'd5, 1'b0}, 1'b0, '0},
    '{1'b0, 4'd0,  '{16'd5, 1'b0}, 1'b0, '0},
    '{1'b0, 4'd0,  '{16'd6, 1'b0}, 1'b0, '0},
    '{1'b0, 4'd0,  '{16'd7, 1'b0}, 1'b0, '0},
    '{1'b0, 4'd0,  '{16'd8, 1'b0}, 1'b0, '0},
    '{1'b0, 4'd0,  '{16'd5, 1'b1}, 1'b0, '0},
    // zero frames acts as one
    '{1'b1, 4'd0,  '{16'd9, 1'b0}, 1'b0, '0},
    '{1'b0, 4'd0,  '{16'd10, 1'b0}, 1'b0, '0},
    '{1'b0, 4'd0,  '{16'd9, 1'b1}, 1'b0, '0},
    // above the frame limit acts as the limit
    '{1'b1, 4'd15, '{16'hAAAA, 1'b0}, 1'b0, '0},
    '{1'b0, 4'd0,  '{16'h5555, 1'b0}, 1'b0, '0},
    '{1'b0, 4'd0,  '{16'hAAAA, 1'b0}, 1'b0, '0},
    '{1'b0, 4'd0,  '{16'h5555, 1'b1}, 1'b0, '0},
    '{1'b0, 4'd0,  '{16'h8001, 1'b1}, 1'b1,
      '{6'd0, 16'h8001, 1'b0, 3'd0, 1'b0, 16'h0, 7'd0, 7'd1, 1'b1}}
  };

  always #5 clk = ~clk;

  optimal_page_replacement_core #(
    .REF_MAX    (REF_MAX),
    .FRAMES_MAX (FRAMES_MAX)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("MISMATCH at %0t: %s", $time, what);
  endtask

  // Replay the loaded string against empty frames and queue one result per reference.
  function automatic void replay_string();
    logic [PAGE_W-1:0]  fpage  [FRAMES_MAX];
    logic               fvalid [FRAMES_MAX];
    logic [COUNT_W-1:0] hits;
    logic [COUNT_W-1:0] misses;
    logic               hit;
    logic               found;
    int                 nf;
    int                 n;
    int                 best;
    int                 nxt;
    int                 victim;
    out_item_t          r;
    nf = (frames_reg == 0) ? 1 : (int'(frames_reg) > FRAMES_MAX) ? FRAMES_MAX : int'(frames_reg);
    n = loaded_pages.size();
    hits = '0;
    misses = '0;
    for (int j = 0; j < FRAMES_MAX; j++) begin
      fvalid[j] = 1'b0;
      fpage[j] = '0;
    end
    for (int i = 0; i < n; i++) begin
      r = '0;
      r.ref_index = REF_IDX_W'(i);
      r.page_res = loaded_pages[i];
      hit = 1'b0;
      for (int j = 0; j < nf; j++)
        if (fvalid[j] && fpage[j] == loaded_pages[i]) hit = 1'b1;
      if (hit) begin
        hits++;
      end else begin
        victim = i;
        if (i >= nf) begin
          // empty or never-again frame wins at once; else farthest next use
          victim = 0;
          best = i;
          found = 1'b0;
          for (int j = 0; j < nf && !found; j++) begin
            nxt = n;
            if (fvalid[j])
              for (int k = n - 1; k > i; k--)
                if (loaded_pages[k] == fpage[j]) nxt = k;
            if (nxt >= n) begin
              victim = j;
              found = 1'b1;
            end else if (nxt > best) begin
              best = nxt;
              victim = j;
            end
          end
        end
        r.victim_frame = VICTIM_W'(victim);
        r.evicted_valid = fvalid[victim];
        if (fvalid[victim]) r.evicted_page = fpage[victim];
        fpage[victim] = loaded_pages[i];
        fvalid[victim] = 1'b1;
        misses++;
      end
      r.hit = hit;
      r.hit_count = hits;
      r.miss_count = misses;
      r.last_result = (i == n - 1);
      replay_due.push_back(r);
    end
    loaded_pages.delete();
  endfunction

  task automatic send_word(input in_item_t w);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (busy);
    words_sent++;
    // drop words past the end of the store
    if (loaded_pages.size() < REF_MAX) loaded_pages.push_back(w.page);
    if (w.last_ref) replay_string();
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (replay_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_frames(input logic [CFG_W-1:0] v);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    frames_reg = v;
  endtask

  always @(posedge clk) begin : result_check
    out_item_t want;
    string     bad;
    if (rst_n) begin
      if (out_valid || (start && !busy) || (cfg_valid && cfg_ready)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("optimal_page_replacement_core test failed");
        $finish;
      end else if (out_valid) begin
        if (replay_due.size() == 0) begin
          report_mismatch($sformatf("result for ref %0d with nothing expected",
                                    out_data.ref_index));
        end else begin
          want = replay_due.pop_front();
          bad = "";
          if (out_data.ref_index !== want.ref_index) bad = {bad, " ref_index"};
          if (out_data.page_res !== want.page_res) bad = {bad, " page_res"};
          if (out_data.hit !== want.hit) bad = {bad, " hit"};
          if (out_data.victim_frame !== want.victim_frame) bad = {bad, " victim_frame"};
          if (out_data.evicted_valid !== want.evicted_valid) bad = {bad, " evicted_valid"};
          if (out_data.evicted_page !== want.evicted_page) bad = {bad, " evicted_page"};
          if (out_data.hit_count !== want.hit_count) bad = {bad, " hit_count"};
          if (out_data.miss_count !== want.miss_count) bad = {bad, " miss_count"};
          if (out_data.last_result !== want.last_result) bad = {bad, " last_result"};
          if (bad != "")
            report_mismatch($sformatf("ref %0d wrong%s: got %h want %h",
                                      want.ref_index, bad, out_data, want));
        end
      end
    end
  end

  initial begin
    dir_row_t          row;
    in_item_t          w;
    logic [PAGE_W-1:0] pool [10];
    logic [PAGE_W-1:0] base;
    logic              noise;
    int                len;
    int                pool_n;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    idle_pct = 37;
    for (int r = 0; r < DIR_N; r++) begin
      row = dir_table[r];
      if (row.cfg_wr) write_frames(row.cfg_val);
      send_word(row.word);
      // single-word string: replace the computed result with the typed one
      if (row.typed) replay_due[replay_due.size() - 1] = row.want;
    end

    words_sent = 0;
    for (int s = 0; words_sent < RAND_WORDS; s++) begin
      idle_pct = (words_sent < RAND_WORDS / 3) ? 37 :
                 (words_sent < 2 * RAND_WORDS / 3) ? 64 : 0;
      case (s)
        0: write_frames(4'd15);
        1: write_frames(4'd0);
        2: write_frames(4'd1);
        3: write_frames(4'd9);
        4: write_frames(4'd5);
        5: write_frames(4'd8);
        default: if ($urandom_range(2) == 0) write_frames(CFG_W'($urandom_range(15)));
      endcase
      if (s == 2 || s == 5) begin
        // overflow the store: all misses on one frame, or one page that hits after its first miss
        len = (s == 2) ? 66 : 65;
        base = PAGE_W'($urandom);
        for (int i = 1; i <= len; i++) begin
          w.page = (s == 2) ? base + PAGE_W'(i) : base;
          w.last_ref = (i == len);
          send_word(w);
        end
      end else begin
        noise = ($urandom_range(4) == 0);
        len = noise ? $urandom_range(8, 1) : $urandom_range(24, 2);
        pool_n = $urandom_range(10, 1);
        for (int j = 0; j < 10; j++) pool[j] = PAGE_W'($urandom);
        for (int i = 1; i <= len; i++) begin
          w.page = noise ? PAGE_W'($urandom) : pool[$urandom_range(pool_n - 1)];
          w.last_ref = (i == len);
          send_word(w);
        end
      end
    end

    drain_results();
    if (mismatches == 0)
      $display("optimal_page_replacement_core test passed");
    else
      $display("optimal_page_replacement_core test failed");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/opr_pkg.sv
rtl/opr_ctrl.sv
rtl/opr_dpath.sv
rtl/optimal_page_replacement_core.sv
bench/tb.sv
